>>> rtl/mbps_pkg.sv
// Shared types and constants for the masked byte pattern search block.
// No dependencies; every other file in rtl/ uses this package.
`timescale 1ns / 1ps
`default_nettype none

package mbps_pkg;

	// Pattern and mask registers hold a fixed number of byte lanes.
	localparam int REG_BYTES    = 12;
	localparam int REG_BITS     = REG_BYTES * 8;
	localparam int OUT_OFFSET_W = 24;
	localparam int CFG_INDEX_W  = 3;
	localparam int CFG_DATA_W   = 64;
	localparam int LEN_W        = 4;

	// Register reset values.
	localparam logic [LEN_W-1:0] LEN_RESET = 4'd4;

	// Configuration register indexes.
	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_PATTERN_LO = 3'd0,
		REG_PATTERN_HI = 3'd1,
		REG_MASK_LO    = 3'd2,
		REG_MASK_HI    = 3'd3,
		REG_LENGTH     = 3'd4
	} cfg_idx_t;

	// Current configuration as seen by the compare logic.
	typedef struct packed {
		logic [REG_BITS-1:0] pattern;
		logic [REG_BITS-1:0] mask;
		logic [LEN_W-1:0]    length;   // already clamped to the usable range
	} cfg_t;

	// Compare outcome for the word in flight.
	typedef struct packed {
		logic                    hit;
		logic [OUT_OFFSET_W-1:0] offset;
	} cmp_t;

endpackage

`default_nettype wire

>>> rtl/mbps_cfg_regs.sv
// Configuration register file for the masked byte pattern search block.
// Depends on mbps_pkg; the pattern length is clamped when it is written.
`timescale 1ns / 1ps
`default_nettype none

module mbps_cfg_regs #(
	parameter int LIMIT = 12
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               cfg_we,
	input  wire logic [mbps_pkg::CFG_INDEX_W-1:0]   cfg_index,
	input  wire logic [mbps_pkg::CFG_DATA_W-1:0]    cfg_data,
	output mbps_pkg::cfg_t                          cfg
);

	localparam logic [mbps_pkg::LEN_W-1:0] LIM = mbps_pkg::LEN_W'(LIMIT);

	// Zero counts as one byte, anything above the window depth as the full depth.
	function automatic logic [mbps_pkg::LEN_W-1:0] clamp_len(
		input logic [mbps_pkg::LEN_W-1:0] v
	);
		logic [mbps_pkg::LEN_W-1:0] r;
		r = v;
		if (v == '0) begin
			r = mbps_pkg::LEN_W'(1);
		end else if (v > LIM) begin
			r = LIM;
		end
		return r;
	endfunction

	logic [mbps_pkg::REG_BITS-1:0] pattern_q;
	logic [mbps_pkg::REG_BITS-1:0] mask_q;
	logic [mbps_pkg::LEN_W-1:0]    length_q;

	// Register writes; high registers take only their low 32 bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pattern_q <= '0;
			mask_q    <= '1;
			length_q  <= clamp_len(mbps_pkg::LEN_RESET);
		end else if (cfg_we) begin
			case (cfg_index)
				mbps_pkg::REG_PATTERN_LO: pattern_q[63:0]  <= cfg_data;
				mbps_pkg::REG_PATTERN_HI: pattern_q[95:64] <= cfg_data[31:0];
				mbps_pkg::REG_MASK_LO:    mask_q[63:0]     <= cfg_data;
				mbps_pkg::REG_MASK_HI:    mask_q[95:64]    <= cfg_data[31:0];
				mbps_pkg::REG_LENGTH:     length_q <= clamp_len(cfg_data[mbps_pkg::LEN_W-1:0]);
				default: ;
			endcase
		end
	end

	assign cfg.pattern = pattern_q;
	assign cfg.mask    = mask_q;
	assign cfg.length  = length_q;

endmodule

`default_nettype wire

>>> rtl/mbps_window_cmp.sv
// Parallel masked compare of the byte window against the pattern.
// Depends on mbps_pkg; purely combinational, sits between the stage registers.
`timescale 1ns / 1ps
`default_nettype none

module mbps_window_cmp #(
	parameter int WIN         = 12,
	parameter int OFFSET_BITS = 24
) (
	input  wire logic [WIN-1:0][7:0]        window,   // index 0 is the newest byte
	input  wire logic [OFFSET_BITS-1:0]     count,
	input  wire mbps_pkg::cfg_t             cfg,
	output mbps_pkg::cmp_t                  cmp
);

	logic [WIN-1:0][7:0]       aligned;
	logic [WIN-1:0]            byte_ok;
	logic [OFFSET_BITS-1:0]    len_ext;
	logic [OFFSET_BITS-1:0]    diff;

	// Pattern byte i lines up with window byte (length - 1 - i).
	always_comb begin
		for (int i = 0; i < WIN; i++) begin
			aligned[i] = '0;
			for (int j = 0; j < WIN; j++) begin
				if (int'(cfg.length) - 1 - i == j) begin
					aligned[i] = window[j];
				end
			end
		end
	end

	// Lanes beyond the pattern length always agree.
	always_comb begin
		for (int i = 0; i < WIN; i++) begin
			byte_ok[i] = (i >= int'(cfg.length)) ||
				((cfg.pattern[i*8 +: 8] & cfg.mask[i*8 +: 8]) ==
				 (aligned[i] & cfg.mask[i*8 +: 8]));
		end
	end

	// A hit needs a full pattern's worth of bytes in this buffer.
	assign len_ext    = OFFSET_BITS'(cfg.length);
	assign diff       = count - len_ext;
	assign cmp.hit    = (&byte_ok) && (count >= len_ext);
	assign cmp.offset = mbps_pkg::OUT_OFFSET_W'(diff);

endmodule

`default_nettype wire

>>> rtl/masked_byte_pattern_search.sv
// Masked byte pattern search: scans a buffer one byte per word and reports
// the offset of the first match of a 1 to 12 byte pattern under a per-byte
// mask, or a single not-found word when the buffer ends without a match. It
// takes one byte every cycle while the result register is free or draining;
// a byte passes an input register, the parallel window compare and lands in
// the result register, and a stalled result holds back only the one byte
// behind it. The offset counter saturates at 2^OFFSET_BITS - 1.
// Depends on mbps_pkg, mbps_cfg_regs and mbps_window_cmp.
`timescale 1ns / 1ps
`default_nettype none

module masked_byte_pattern_search #(
	parameter int MAX_PATTERN_BYTES = 12,
	parameter int OFFSET_BITS       = 24
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	// Configuration write port
	input  wire logic                                 cfg_we,
	input  wire logic [mbps_pkg::CFG_INDEX_W-1:0]     cfg_index,
	input  wire logic [mbps_pkg::CFG_DATA_W-1:0]      cfg_data,
	// Byte stream in
	input  wire logic                                 s_tvalid,
	output logic                                      s_tready,
	input  wire logic [7:0]                           s_tdata,   // [7:0] data_byte
	input  wire logic                                 s_tlast,   // last_byte
	// Result stream out
	output logic                                      m_tvalid,
	input  wire logic                                 m_tready,
	output logic [mbps_pkg::OUT_OFFSET_W-1:0]         m_tdata,   // [23:0] match_offset
	output logic                                      m_tuser    // found
);

	localparam int WIN = (MAX_PATTERN_BYTES < mbps_pkg::REG_BYTES) ?
		MAX_PATTERN_BYTES : mbps_pkg::REG_BYTES;

	mbps_pkg::cfg_t cfg;
	mbps_pkg::cmp_t cmp;

	logic                        valid_s1;
	logic [7:0]                  data_s1;
	logic                        last_s1;

	logic [WIN-1:0][7:0]         window_q;
	logic [WIN-1:0][7:0]         window_next;
	logic [OFFSET_BITS-1:0]      count_q;
	logic [OFFSET_BITS-1:0]      count_next;
	logic                        matched_q;

	logic                        advance;
	logic                        emit_found;
	logic                        emit_miss;

	mbps_cfg_regs #(
		.LIMIT (WIN)
	) u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// The staged word moves on whenever the result register is free or draining.
	assign advance  = valid_s1 && (!m_tvalid || m_tready);
	assign s_tready = !valid_s1 || advance;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready) begin
			data_s1 <= s_tdata;
			last_s1 <= s_tlast;
		end
	end

	// Window with the staged byte shifted in, and the saturating byte count.
	always_comb begin
		window_next[0] = data_s1;
		for (int k = 1; k < WIN; k++) begin
			window_next[k] = window_q[k-1];
		end
	end

	assign count_next = (count_q == '1) ? count_q : count_q + OFFSET_BITS'(1);

	mbps_window_cmp #(
		.WIN         (WIN),
		.OFFSET_BITS (OFFSET_BITS)
	) u_cmp (
		.window (window_next),
		.count  (count_next),
		.cfg    (cfg),
		.cmp    (cmp)
	);

	assign emit_found = advance && !matched_q && cmp.hit;
	assign emit_miss  = advance && !matched_q && !cmp.hit && last_s1;

	// Buffer state; the last byte returns everything to a fresh buffer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q  <= '0;
			count_q   <= '0;
			matched_q <= 1'b0;
		end else if (advance) begin
			if (last_s1) begin
				window_q  <= '0;
				count_q   <= '0;
				matched_q <= 1'b0;
			end else begin
				window_q  <= window_next;
				count_q   <= count_next;
				matched_q <= matched_q || cmp.hit;
			end
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (emit_found || emit_miss) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_found || emit_miss) begin
			m_tuser <= emit_found;
			m_tdata <= emit_found ? cmp.offset : '0;
		end
	end

endmodule

`default_nettype wire

>>> rtl/mbps_checker.sv
// Port-level checks for the masked byte pattern search block.
// Depends on mbps_pkg; attached to the top level by the bind below.
`timescale 1ns / 1ps
`default_nettype none

module mbps_checker (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 s_tready,
	input  wire logic                                 m_tvalid,
	input  wire logic                                 m_tready,
	input  wire logic [mbps_pkg::OUT_OFFSET_W-1:0]    m_tdata,
	input  wire logic                                 m_tuser
);

	// A not-found word always carries a zero offset.
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tuser) |-> (m_tdata == '0))
		else $error("not-found word with nonzero offset");

	// An empty result register never blocks the input.
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input stalled while no result is pending");

	// A stalled result holds its word.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
		else $error("result changed while stalled");

endmodule

bind masked_byte_pattern_search mbps_checker u_mbps_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);

`default_nettype wire

>>> tb/sv/tb.sv
// Self-checking bench for masked_byte_pattern_search: drives byte buffers and pattern setups,
// predicts each found/not-found word and compares it with the block's result stream.
// Depends on mbps_pkg and the masked_byte_pattern_search RTL.
`timescale 1ns / 1ps

module tb;

	localparam int WINDOW_BYTES  = 12;
	localparam int MAX_FRAME     = 512;
	localparam int NUM_PHASES    = 16;
	localparam int PHASE_ITEMS   = 42;
	localparam int SETTLE_CYCLES = 8;
	localparam int DRAIN_LIMIT   = 4000;
	localparam int HOLD_CYCLES   = 80;
	localparam int MAX_REPORTS   = 200;

	// Twelve distinct edge values, byte 0 in the low bits.
	localparam logic [mbps_pkg::REG_BITS-1:0] EDGE_PATTERN = 96'hCC33F00F_AA55FE7F_8001FF00;

	typedef struct packed {
		logic                              found;
		logic [mbps_pkg::OUT_OFFSET_W-1:0] offset;
	} search_result_t;

	// Predicts the search outcome per byte and holds the results still owed by the block.
	class match_predictor;
		logic [mbps_pkg::REG_BITS-1:0]     pattern;
		logic [mbps_pkg::REG_BITS-1:0]     mask;
		logic [mbps_pkg::LEN_W-1:0]        length_reg;
		logic [7:0]                        window [WINDOW_BYTES];
		logic [mbps_pkg::OUT_OFFSET_W-1:0] seen;
		bit                                matched;
		search_result_t                    expected_results [$];
		int                                errors;
		int                                checked;

		function new();
			pattern = '0;
			mask = '1;
			length_reg = mbps_pkg::LEN_RESET;
			errors = 0;
			checked = 0;
			clear_buffer();
		endfunction

		function void clear_buffer();
			foreach (window[i])
				window[i] = 8'h00;
			seen = '0;
			matched = 1'b0;
		endfunction

		// Zero counts as one byte; anything above the lane count is clamped to it.
		function int eff_len();
			int len;
			len = length_reg;
			if (len == 0)
				len = 1;
			if (len > WINDOW_BYTES)
				len = WINDOW_BYTES;
			return len;
		endfunction

		function void write_reg(mbps_pkg::cfg_idx_t idx, logic [mbps_pkg::CFG_DATA_W-1:0] v);
			case (idx)
				mbps_pkg::REG_PATTERN_LO: pattern[63:0] = v;
				mbps_pkg::REG_PATTERN_HI: pattern[95:64] = v[31:0];
				mbps_pkg::REG_MASK_LO:    mask[63:0] = v;
				mbps_pkg::REG_MASK_HI:    mask[95:64] = v[31:0];
				mbps_pkg::REG_LENGTH:     length_reg = v[mbps_pkg::LEN_W-1:0];
				default: ;
			endcase
		endfunction

		// Shift in one accepted byte and queue the result it causes, if any.
		function void take_byte(logic [7:0] b, logic last);
			int i;
			int len;
			bit hit;
			logic [7:0] m;
			search_result_t r;
			for (i = WINDOW_BYTES - 1; i > 0; i--)
				window[i] = window[i - 1];
			window[0] = b;
			if (seen != '1)
				seen++;
			len = eff_len();
			hit = 1'b0;
			if (!matched && seen >= len) begin
				hit = 1'b1;
				for (i = 0; i < len; i++) begin
					m = mask[8*i +: 8];
					if ((pattern[8*i +: 8] & m) != (window[len - 1 - i] & m))
						hit = 1'b0;
				end
			end
			if (hit) begin
				matched = 1'b1;
				r.found = 1'b1;
				r.offset = seen - mbps_pkg::OUT_OFFSET_W'(len);
				expected_results.push_back(r);
			end else if (!matched && last) begin
				r.found = 1'b0;
				r.offset = '0;
				expected_results.push_back(r);
			end
			if (last)
				clear_buffer();
		endfunction

		task report(string msg);
			errors++;
			// Keep the log readable if the block is badly broken.
			if (errors <= MAX_REPORTS)
				$display("MISMATCH: %s", msg);
		endtask

		task check_result(logic found, logic [mbps_pkg::OUT_OFFSET_W-1:0] offset);
			search_result_t e;
			checked++;
			if (expected_results.size() == 0) begin
				report($sformatf("word %0d: found %0b offset %0d with nothing expected",
					checked, found, offset));
			end else begin
				e = expected_results.pop_front();
				if (found !== e.found || offset !== e.offset)
					report($sformatf("word %0d: found %0b offset %0d, expected %0b offset %0d",
						checked, found, offset, e.found, e.offset));
			end
		endtask

		task flush_leftovers();
			search_result_t e;
			while (expected_results.size() != 0) begin
				e = expected_results.pop_front();
				report($sformatf("missing word: found %0b offset %0d", e.found, e.offset));
			end
		endtask
	endclass

	logic                              clk = 1'b0;
	logic                              arst_n;
	logic                              cfg_we;
	logic [mbps_pkg::CFG_INDEX_W-1:0]  cfg_index;
	logic [mbps_pkg::CFG_DATA_W-1:0]   cfg_data;
	logic                              s_tvalid;
	logic                              s_tready;
	logic [7:0]                        s_tdata;   // [7:0] data_byte
	logic                              s_tlast;   // last_byte
	logic                              m_tvalid;
	logic                              m_tready;
	logic [mbps_pkg::OUT_OFFSET_W-1:0] m_tdata;   // [23:0] match_offset
	logic                              m_tuser;   // found

	match_predictor sb = new();

	bit         tx_gaps = 1'b1;
	bit         rx_gaps = 1'b1;
	int         rx_hold_cycles = 0;
	int         items_sent = 0;
	logic [7:0] frame_bytes [0:MAX_FRAME-1];
	int         frame_len;

	masked_byte_pattern_search dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

	always #4 clk = ~clk;

	// Watch both streams; a byte is noted before any result of the same edge is checked.
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready)
				sb.take_byte(s_tdata, s_tlast);
			if (m_tvalid && m_tready)
				sb.check_result(m_tuser, m_tdata);
		end
	end

	// Result side: random stall bursts, plus one long hold-off when requested.
	initial begin : rx_side
		int hold;
		m_tready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (rx_hold_cycles > 0) begin
				hold = rx_hold_cycles;
				rx_hold_cycles = 0;
				m_tready <= 1'b0;
				repeat (hold - 1) @(posedge clk);
			end else if (rx_gaps && $urandom_range(0, 3) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(0, 3)) @(posedge clk);
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// Run limit, far above the slowest correct run.
	initial begin
		#(4_000_000);
		$display("CHECKS FAILED");
		$finish;
	end

	// Offer one byte, with an optional idle burst first, and wait until it is taken.
	task automatic send_byte(input logic [7:0] b, input logic last);
		if (tx_gaps && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= b;
		s_tlast <= last;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		items_sent++;
	endtask

	// Stop offering and wait until every owed result has come, then let the pipe settle.
	task automatic drain_results();
		int guard;
		s_tvalid <= 1'b0;
		guard = 0;
		while (sb.expected_results.size() != 0 && guard < DRAIN_LIMIT) begin
			@(posedge clk);
			guard++;
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
		sb.flush_leftovers();
	endtask

	task automatic cfg_write(input mbps_pkg::cfg_idx_t idx,
			input logic [mbps_pkg::CFG_DATA_W-1:0] v);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		sb.write_reg(idx, v);
		@(posedge clk);
	endtask

	// Write all five registers; unused upper data bits sometimes carry junk.
	task automatic write_config(input logic [mbps_pkg::REG_BITS-1:0] pat,
			input logic [mbps_pkg::REG_BITS-1:0] msk, input logic [mbps_pkg::LEN_W-1:0] len);
		logic [mbps_pkg::CFG_DATA_W-1:0] junk;
		junk = ($urandom_range(0, 1) == 0) ? '0 : {$urandom, $urandom};
		cfg_write(mbps_pkg::REG_PATTERN_LO, pat[63:0]);
		cfg_write(mbps_pkg::REG_PATTERN_HI, {junk[63:32], pat[95:64]});
		cfg_write(mbps_pkg::REG_MASK_LO, msk[63:0]);
		cfg_write(mbps_pkg::REG_MASK_HI, {junk[31:0], msk[95:64]});
		cfg_write(mbps_pkg::REG_LENGTH, {junk[63:mbps_pkg::LEN_W], len});
		cfg_we <= 1'b0;
	endtask

	task automatic random_config();
		logic [mbps_pkg::REG_BITS-1:0] pat;
		logic [mbps_pkg::REG_BITS-1:0] msk;
		logic [mbps_pkg::LEN_W-1:0] len;
		int i;
		int pick;
		for (i = 0; i < WINDOW_BYTES; i++) begin
			pick = $urandom_range(0, 9);
			pat[8*i +: 8] = (pick == 0) ? 8'h00 : (pick == 1) ? 8'hFF : 8'($urandom);
			pick = $urandom_range(0, 7);
			msk[8*i +: 8] = (pick < 4) ? 8'hFF : (pick == 4) ? 8'h00 : 8'($urandom);
		end
		// Now and then a length of zero or above the lane count.
		if ($urandom_range(0, 9) == 0) begin
			pick = $urandom_range(0, 3);
			len = (pick == 0) ? 4'd0 : mbps_pkg::LEN_W'(12 + pick);
		end else begin
			len = mbps_pkg::LEN_W'($urandom_range(1, 12));
		end
		write_config(pat, msk, len);
	endtask

	// Random buffer, usually with the pattern planted somewhere, sometimes at the very end.
	task automatic build_frame();
		int i;
		int j;
		int at;
		int len;
		bit narrow;
		logic [7:0] p;
		logic [7:0] m;
		len = sb.eff_len();
		frame_len = ($urandom_range(0, 15) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 24);
		narrow = $urandom_range(0, 1);
		for (i = 0; i < frame_len; i++) begin
			j = $urandom_range(0, WINDOW_BYTES - 1);
			frame_bytes[i] = narrow ? sb.pattern[8*j +: 8] : 8'($urandom);
		end
		if ($urandom_range(0, 2) != 0) begin
			if (frame_len >= len && $urandom_range(0, 2) == 0)
				at = frame_len - len;
			else
				at = $urandom_range(0, frame_len);
			for (i = 0; i < len && at + i < frame_len; i++) begin
				p = sb.pattern[8*i +: 8];
				m = sb.mask[8*i +: 8];
				frame_bytes[at + i] = (p & m) | (8'($urandom) & ~m);
			end
		end
	endtask

	// Send the buffer; occasionally the setup changes halfway through it.
	task automatic send_frame();
		int i;
		int split;
		split = (frame_len >= 4 && $urandom_range(0, 9) == 0) ? frame_len / 2 : -1;
		for (i = 0; i < frame_len; i++) begin
			if (i == split) begin
				drain_results();
				random_config();
			end
			send_byte(frame_bytes[i], i == frame_len - 1);
		end
	endtask

	initial begin : stimulus
		int i;
		int phase;
		int start;
		bit quiet_tail;
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= mbps_pkg::REG_PATTERN_LO;
		cfg_data <= '0;
		s_tvalid <= 1'b0;
		s_tdata <= 8'h00;
		s_tlast <= 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset setup (zero pattern, length four): a short zero buffer must not match the
		// cleared window, and a match needs four real bytes.
		send_byte(8'h00, 1'b0);
		send_byte(8'h00, 1'b0);
		send_byte(8'h00, 1'b1);
		send_byte(8'hFF, 1'b0);
		for (i = 0; i < 4; i++)
			send_byte(8'h00, i == 3);

		// Full twelve-byte pattern found only at the last candidate position.
		drain_results();
		write_config(EDGE_PATTERN, '1, 4'd12);
		for (i = 0; i < WINDOW_BYTES; i++)
			send_byte(EDGE_PATTERN[8*i +: 8], i == WINDOW_BYTES - 1);

		// Length zero acts as one byte; bytes after a match give nothing.
		drain_results();
		write_config({88'h0, 8'hFF}, '1, 4'd0);
		send_byte(8'h00, 1'b0);
		send_byte(8'hFF, 1'b1);
		send_byte(8'hFF, 1'b0);
		send_byte(8'hFF, 1'b1);

		// Random phases, each under its own setup; the last few run without idling.
		for (phase = 0; phase < NUM_PHASES; phase++) begin
			drain_results();
			quiet_tail = phase >= NUM_PHASES - 3;
			tx_gaps = !quiet_tail && (phase % 4 != 3);
			rx_gaps = !quiet_tail && (phase % 4 != 2);
			case (phase)
				0: write_config('1, '1, 4'd12);
				1: write_config({$urandom, $urandom, $urandom}, '0, 4'd1);
				2: write_config({$urandom, $urandom, $urandom}, '1, 4'd15);
				3: begin
					// Every one-byte buffer matches; a long result hold-off backs up the input.
					write_config({$urandom, $urandom, $urandom}, '0, 4'd1);
					rx_hold_cycles = HOLD_CYCLES;
					for (i = 0; i < 40; i++)
						send_byte(8'($urandom), 1'b1);
				end
				default: random_config();
			endcase
			start = items_sent;
			while (items_sent - start < PHASE_ITEMS) begin
				build_frame();
				send_frame();
			end
		end

		drain_results();
		if (sb.errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
